// ----- design/frpb_pkg.sv -----
// Package for the frame reassembly playout buffer.
// Result and slot record types, release kinds, window size. No dependencies.
package frpb_pkg;

  localparam int unsigned FRAME_W = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PIDX_W  = 6;
  localparam int unsigned PCNT_W  = 7;
  localparam int unsigned MAP_W   = 64;
  // slot index is the low bits of the frame number, so a power of two
  localparam int unsigned WINDOW  = 32;

  typedef enum logic [1:0] {
    KIND_DECODED   = 2'd0,
    KIND_DISCARDED = 2'd1,
    KIND_DROPPED   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [FRAME_W-1:0] released_frame;
    kind_t              release_kind;
    logic               ack_due;
    logic [TIME_W-1:0]  frame_encode_time_ms;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    logic [PCNT_W-1:0] needed;
    logic [PCNT_W-1:0] got;
    logic [TIME_W-1:0] enc;
    logic [MAP_W-1:0]  map;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

endpackage

// ----- design/frpb_if.sv -----
// Valid/ready channel interfaces for the frame reassembly playout buffer.
// Depends on frpb_pkg.
interface frpb_in_if;
  logic                          valid;
  logic                          ready;
  logic [frpb_pkg::FRAME_W-1:0]  frame_number;
  logic [frpb_pkg::PIDX_W-1:0]   packet_index;
  logic [frpb_pkg::PCNT_W-1:0]   packets_in_frame;
  logic [frpb_pkg::TIME_W-1:0]   encode_time_ms;
  modport source (output valid, frame_number, packet_index, packets_in_frame,
                  encode_time_ms, input ready);
  modport sink (input valid, frame_number, packet_index, packets_in_frame,
                encode_time_ms, output ready);
endinterface

interface frpb_out_if;
  logic                          valid;
  logic                          ready;
  logic [frpb_pkg::FRAME_W-1:0]  released_frame;
  logic [1:0]                    release_kind;
  logic                          ack_due;
  logic [frpb_pkg::TIME_W-1:0]   frame_encode_time_ms;
  logic                          last_of_run;
  modport source (output valid, released_frame, release_kind, ack_due,
                  frame_encode_time_ms, last_of_run, input ready);
  modport sink (input valid, released_frame, release_kind, ack_due,
                frame_encode_time_ms, last_of_run, output ready);
endinterface

interface frpb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- design/frpb_ram.sv -----
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module frpb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/frame_reassembly_playout_buffer.sv -----
// Channel   | dir | payload
// in_ch     | in  | frame_number, packet_index, packets_in_frame, encode_time_ms
// out_ch    | out | released_frame, release_kind, ack_due, frame_encode_time_ms, last_of_run
// cfg_ch    | in  | deadline_frames (8 bits)
// One packet at a time. A stored packet passes walk read, walk decide, check, store decide
// and done before the next accept; a packet of a played frame returns to idle from walk
// read. Each deadline discard or walk release adds a slot read and decide; an in-order
// completion adds a read and decide per frame released plus a final pair. The newest
// result waits in a hold register until the next one or the step end; emitting states
// and done stall while hold and output registers are full and unread. Reset clears valid
// bits, frame state and flags, sets deadline 10. Depends on frpb_pkg, frpb_if, frpb_ram.
module frame_reassembly_playout_buffer #(
  parameter int unsigned MAX_PACKETS = 64
) (
  input  logic clk,
  input  logic rst_n,
  frpb_in_if.sink    in_ch,
  frpb_out_if.source out_ch,
  frpb_cfg_if.sink   cfg_ch
);
  localparam int unsigned WINDOW = frpb_pkg::WINDOW;
  localparam int unsigned AW = $clog2(WINDOW);
  localparam int unsigned FW = frpb_pkg::FRAME_W;
  localparam int unsigned MW = frpb_pkg::MAP_W;
  localparam int unsigned PW = frpb_pkg::PCNT_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_WREAD  = 8'b00000010,
    S_WDEC   = 8'b00000100,
    S_CHECK  = 8'b00001000,
    S_SDEC   = 8'b00010000,
    S_RREAD  = 8'b00100000,
    S_RDEC   = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]        dl_r;
  logic [WINDOW-1:0] valid_r, valid_nxt;
  logic [FW-1:0]     last_r, last_nxt;
  logic              any_r, any_nxt;
  logic [FW-1:0]     high_r, high_nxt;

  logic [FW-1:0]               f_r, f_nxt;
  logic [frpb_pkg::PIDX_W-1:0] pi_r, pi_nxt;
  logic [PW-1:0]               pc_r, pc_nxt;
  logic [frpb_pkg::TIME_W-1:0] enc_r, enc_nxt;
  logic                        tgt_ok_r, tgt_ok_nxt;
  logic [FW-1:0]               tgt_r, tgt_nxt;
  logic                        did_r, did_nxt;
  logic [AW:0]                 steps_r, steps_nxt;

  frpb_pkg::result_t res_r, res_nxt;
  logic              ov_r, ov_nxt;
  logic              pend_r, pend_nxt;
  frpb_pkg::result_t pres_r, pres_nxt;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  frpb_pkg::slot_t      wdata, rdata;

  frpb_ram #(.WIDTH(frpb_pkg::SLOT_W), .DEPTH(WINDOW)) u_slots (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [FW-1:0] nf;
  logic [AW-1:0] ns, fs;
  logic          exh, played;
  logic          ns_complete;
  logic          emit_ok;
  logic          walk_go, walk_rel, walk_dis;

  assign nf     = any_r ? last_r + 1'b1 : '0;
  assign ns     = nf[AW-1:0];
  assign fs     = f_r[AW-1:0];
  assign exh    = any_r && (last_r == '1);
  assign played = exh || (any_r && f_r <= last_r);
  assign ns_complete = valid_r[ns] && (rdata.got == rdata.needed);
  assign emit_ok = !pend_r || !ov_r || out_ch.ready;

  assign walk_go  = (steps_r < (AW+1)'(WINDOW)) && !exh;
  assign walk_rel = walk_go && did_r && ns_complete;
  assign walk_dis = walk_go && !walk_rel && tgt_ok_r && (nf <= tgt_r);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid                = ov_r;
  assign out_ch.released_frame       = res_r.released_frame;
  assign out_ch.release_kind         = res_r.release_kind;
  assign out_ch.ack_due              = res_r.ack_due;
  assign out_ch.frame_encode_time_ms = res_r.frame_encode_time_ms;
  assign out_ch.last_of_run          = res_r.last_of_run;

  // Store computation for the packet slot
  frpb_pkg::slot_t st;
  logic [MW-1:0]   bit_m;

  always_comb begin
    bit_m = (32'(pi_r) < MAX_PACKETS) ? (MW'(1) << pi_r) : '0;
    if (!valid_r[fs]) begin
      st.map    = bit_m;
      st.needed = pc_r;
      st.enc    = enc_r;
      st.got    = PW'(bit_m != '0);
    end else begin
      st.map    = rdata.map | bit_m;
      st.needed = rdata.needed;
      st.enc    = (enc_r < rdata.enc) ? enc_r : rdata.enc;
      st.got    = rdata.got + PW'((bit_m & ~rdata.map) != '0);
    end
  end

  logic              emit_req, fin_req;
  frpb_pkg::result_t emit_res;

  always_comb begin
    state_nxt  = state_r;
    valid_nxt  = valid_r;
    last_nxt   = last_r;
    any_nxt    = any_r;
    high_nxt   = high_r;
    f_nxt      = f_r;
    pi_nxt     = pi_r;
    pc_nxt     = pc_r;
    enc_nxt    = enc_r;
    tgt_ok_nxt = tgt_ok_r;
    tgt_nxt    = tgt_r;
    did_nxt    = did_r;
    steps_nxt  = steps_r;
    res_nxt    = res_r;
    ov_nxt     = ov_r && !out_ch.ready;
    pend_nxt   = pend_r;
    pres_nxt   = pres_r;
    we         = 1'b0;
    waddr      = fs;
    wdata      = st;
    raddr      = ns;
    emit_req   = 1'b0;
    fin_req    = 1'b0;
    emit_res   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          f_nxt      = in_ch.frame_number;
          pi_nxt     = in_ch.packet_index;
          pc_nxt     = in_ch.packets_in_frame;
          enc_nxt    = in_ch.encode_time_ms;
          tgt_ok_nxt = in_ch.frame_number >= FW'(dl_r);
          tgt_nxt    = in_ch.frame_number - FW'(dl_r);
          did_nxt    = 1'b0;
          steps_nxt  = '0;
          state_nxt  = S_WREAD;
        end
      end
      S_WREAD: begin
        if (steps_r == '0 && played) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_WDEC;
        end
      end
      S_WDEC: begin
        if (walk_rel || walk_dis) begin
          if (emit_ok) begin
            emit_req = 1'b1;
            emit_res.released_frame = nf;
            emit_res.release_kind = walk_rel ? frpb_pkg::KIND_DECODED :
                                               frpb_pkg::KIND_DISCARDED;
            emit_res.frame_encode_time_ms = valid_r[ns] ? rdata.enc : '0;
            valid_nxt[ns] = 1'b0;
            last_nxt = nf;
            any_nxt = 1'b1;
            did_nxt = 1'b1;
            steps_nxt = steps_r + 1'b1;
            state_nxt = S_WREAD;
          end
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        raddr = fs;
        if (played) begin
          state_nxt = S_DONE;
        end else if ((f_r - nf) >= FW'(WINDOW)) begin
          if (emit_ok) begin
            emit_req = 1'b1;
            emit_res.released_frame = f_r;
            emit_res.release_kind = frpb_pkg::KIND_DROPPED;
            emit_res.frame_encode_time_ms = enc_r;
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_SDEC;
        end
      end
      S_SDEC: begin
        raddr = fs;
        if (emit_ok) begin
          we = 1'b1;
          valid_nxt[fs] = 1'b1;
          if (f_r > high_r) high_nxt = f_r;
          state_nxt = S_DONE;
          if (st.got == st.needed) begin
            if (f_r == '0 && !any_r) begin
              emit_req = 1'b1;
              emit_res.released_frame = '0;
              emit_res.release_kind = frpb_pkg::KIND_DECODED;
              emit_res.frame_encode_time_ms = st.enc;
              valid_nxt[fs] = 1'b0;
              last_nxt = '0;
              any_nxt = 1'b1;
            end else if (f_r == nf) begin
              state_nxt = S_RREAD;
            end
          end
        end
      end
      S_RREAD: begin
        if (exh) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RDEC;
        end
      end
      S_RDEC: begin
        if (ns_complete) begin
          if (emit_ok) begin
            emit_req = 1'b1;
            emit_res.released_frame = nf;
            emit_res.release_kind = frpb_pkg::KIND_DECODED;
            emit_res.ack_due = 1'b1;
            emit_res.frame_encode_time_ms = rdata.enc;
            valid_nxt[ns] = 1'b0;
            last_nxt = nf;
            any_nxt = 1'b1;
            state_nxt = S_RREAD;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (emit_ok) begin
          fin_req = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // held result moves out when a newer one arrives or the step ends
    if (emit_req) begin
      if (pend_r) begin
        res_nxt = pres_r;
        ov_nxt  = 1'b1;
      end
      pres_nxt = emit_res;
      pend_nxt = 1'b1;
    end
    if (fin_req && pend_r) begin
      res_nxt = pres_r;
      res_nxt.last_of_run = 1'b1;
      ov_nxt   = 1'b1;
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dl_r    <= 8'd10;
      valid_r <= '0;
      last_r  <= '0;
      any_r   <= 1'b0;
      high_r  <= '0;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) dl_r <= cfg_ch.data;
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
      any_r   <= any_nxt;
      high_r  <= high_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_r      <= f_nxt;
    pi_r     <= pi_nxt;
    pc_r     <= pc_nxt;
    enc_r    <= enc_nxt;
    tgt_ok_r <= tgt_ok_nxt;
    tgt_r    <= tgt_nxt;
    did_r    <= did_nxt;
    steps_r  <= steps_nxt;
    res_r    <= res_nxt;
    pres_r   <= pres_nxt;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> (ov_r && $stable(res_r))) else $error("result lost");
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> state_r == S_SDEC) else $error("slot write outside store");
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_r) else $error("held result in idle");
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
endmodule
